// ===== rtl/core/rfpst_pkg.sv =====
// Package for the frame packet slot tracker: slot entry type, action, status
// and kind codes, sequence wrap bands and the controller state type.
// No dependencies.
package rfpst_pkg;

    localparam int SLOTS_DEFAULT = 64;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_FORCE  = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_STORED = 3'd0;
    localparam logic [2:0] STAT_EMPTY  = 3'd1;
    localparam logic [2:0] STAT_DUP    = 3'd2;
    localparam logic [2:0] STAT_OOW    = 3'd3;
    localparam logic [2:0] STAT_CTRL   = 3'd4;

    // Frame kind of an empty filler or FEC packet.
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // NAL-unit code of a slot that holds no packet.
    localparam logic [2:0] NALU_UNSET = 3'd4;

    localparam logic [16:0] START_CODE_BYTES = 17'd4;

    // Sequence number wrap bands.
    localparam logic [15:0] SEQ_LOW_BAND  = 16'h00ff;
    localparam logic [15:0] SEQ_HIGH_BAND = 16'hff00;

    typedef struct packed {
        logic [16:0] size;
        logic [2:0]  nalu;
        logic        merge;
    } slot_entry_t;

    localparam slot_entry_t SLOT_FREE = '{size: 17'd0, nalu: NALU_UNSET, merge: 1'b0};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_ZERO,
        S_PK_RD,
        S_PK_CHK,
        S_WALK,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/rtp_frame_packet_slot_tracker.sv =====
// Top level of the frame packet slot tracker: controller and frame state.
// Depends on rfpst_pkg and rfpst_slot_mem.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall  | action, seq_num, size_bytes, flags, kinds
//   output  | out       | out_valid / out_stall| status, lengths, offsets, frame state
//
// From one input acceptance to the next: an empty packet, an out-of-window packet
// or a control action goes from S_IDLE to S_DONE, a start action by way of the
// clearing pass; a duplicate passes S_PK_RD and S_PK_CHK. A stored packet adds
// the walk over the slot memory that sums sizes and checks completeness; so does a
// forced last packet after the first one. An earlier packet first moves each slot
// with a read and a write, then frees each slot that the move opened.
// After reset and after each start action a clearing pass writes all SLOTS slots,
// one per cycle, while in_stall stays high. A finished transaction waits in the
// output register, so the next input is taken while out_stall holds it.
module rtp_frame_packet_slot_tracker #(
    parameter int SLOTS = rfpst_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] seq_num,
    input  logic [15:0] size_bytes,
    input  logic        is_first,
    input  logic        marker,
    input  logic [1:0]  frame_kind,
    input  logic [1:0]  nalu_kind,
    input  logic        add_start_code,
    input  logic        merge_first_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [16:0] stored_length,
    output logic [5:0]  slot_index,
    output logic [22:0] byte_offset,
    output logic [22:0] bytes_to_move,
    output logic        frame_complete,
    output logic        have_first,
    output logic        have_last,
    output logic [1:0]  frame_kind_out,
    output logic [15:0] low_seq_out,
    output logic [15:0] high_seq_out
);
    import rfpst_pkg::*;

    localparam int IW = $clog2(SLOTS);

    // Highest-sequence update with wrap bands.
    function automatic logic [15:0] raise_high(input logic [15:0] h, input logic [15:0] s);
        logic [15:0] r;
        r = h;
        if (s > h)
        begin
            if (!(h < SEQ_LOW_BAND && s > SEQ_HIGH_BAND))
            begin
                r = s;
            end
        end
        else if (h > SEQ_HIGH_BAND && s < SEQ_LOW_BAND)
        begin
            r = s;
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [15:0] low_reg, low_next, high_reg, high_next;
    logic [15:0] elow_reg, elow_next, ehigh_reg, ehigh_next;
    logic        seqv_reg, seqv_next, emptyv_reg, emptyv_next;
    logic        first_reg, first_next, last_reg, last_next, cmpl_reg, cmpl_next;
    logic [1:0]  kind_reg, kind_next;
    logic [IW-1:0] hi_reg, hi_next;

    logic [IW-1:0] pk_reg, pk_next, shift_reg, shift_next, rdidx_reg, rdidx_next;
    logic [IW:0]   ptr_reg, ptr_next;
    logic          rdv_reg, rdv_next, allset_reg, allset_next, clres_reg, clres_next;
    logic [16:0]   len_reg, len_next;
    logic [2:0]    nalu_reg, nalu_next, stat_reg, stat_next;
    logic          merge_reg, merge_next, isf_reg, isf_next, mark_reg, mark_next;
    logic [22:0]   off_reg, off_next, mov_reg, mov_next;

    logic        ov_reg, ov_next;
    logic [2:0]  o_stat_reg, o_stat_next;
    logic [16:0] o_len_reg, o_len_next;
    logic [5:0]  o_idx_reg, o_idx_next;
    logic [22:0] o_off_reg, o_off_next, o_mov_reg, o_mov_next;
    logic        o_cmpl_reg, o_cmpl_next, o_first_reg, o_first_next, o_last_reg, o_last_next;
    logic [1:0]  o_kind_reg, o_kind_next;
    logic [15:0] o_low_reg, o_low_next, o_high_reg, o_high_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    slot_entry_t   wr_data, rd_data;

    // Scratch values of the insert decision.
    logic [15:0]        lb, hb, sh16;
    logic signed [18:0] diff;
    logic [17:0]        idx_u, room;
    logic [15:0]        idx16;

    rfpst_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign idx16    = 16'(pk_reg);

    // Next state, datapath updates and memory port control.
    always_comb
    begin
        state_next  = state_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        elow_next   = elow_reg;
        ehigh_next  = ehigh_reg;
        seqv_next   = seqv_reg;
        emptyv_next = emptyv_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        cmpl_next   = cmpl_reg;
        kind_next   = kind_reg;
        hi_next     = hi_reg;
        pk_next     = pk_reg;
        shift_next  = shift_reg;
        rdidx_next  = rdidx_reg;
        ptr_next    = ptr_reg;
        rdv_next    = 1'b0;
        allset_next = allset_reg;
        clres_next  = clres_reg;
        len_next    = len_reg;
        nalu_next   = nalu_reg;
        stat_next   = stat_reg;
        merge_next  = merge_reg;
        isf_next    = isf_reg;
        mark_next   = mark_reg;
        off_next    = off_reg;
        mov_next    = mov_reg;

        ov_next      = ov_reg && out_stall;
        o_stat_next  = o_stat_reg;
        o_len_next   = o_len_reg;
        o_idx_next   = o_idx_reg;
        o_off_next   = o_off_reg;
        o_mov_next   = o_mov_reg;
        o_cmpl_next  = o_cmpl_reg;
        o_first_next = o_first_reg;
        o_last_next  = o_last_reg;
        o_kind_next  = o_kind_reg;
        o_low_next   = o_low_reg;
        o_high_next  = o_high_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = SLOT_FREE;
        rd_addr = '0;

        lb    = seqv_reg ? low_reg : seq_num;
        hb    = seqv_reg ? high_reg : seq_num;
        diff  = $signed({3'b000, seq_num}) - $signed({3'b000, lb});
        if (lb < SEQ_LOW_BAND && seq_num > SEQ_HIGH_BAND)
        begin
            diff = diff - 19'sh10000;
        end
        sh16  = lb - seq_num;
        room  = {2'b00, sh16} + 18'(hi_reg) + 18'd1;
        idx_u = diff[17:0];

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IW-1:0];
                wr_data  = SLOT_FREE;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == (IW+1)'(SLOTS - 1))
                begin
                    clres_next = 1'b0;
                    state_next = clres_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    stat_next = STAT_CTRL;
                    state_next = S_DONE;
                    case (action)
                        ACT_INSERT:
                        begin
                            if (is_first)
                            begin
                                kind_next = frame_kind;
                            end
                            else if (kind_reg == KIND_EMPTY && frame_kind != KIND_EMPTY)
                            begin
                                kind_next = frame_kind;
                            end
                            if (frame_kind == KIND_EMPTY)
                            begin
                                // Empty packets only widen the empty range.
                                stat_next = STAT_EMPTY;
                                if (!emptyv_reg)
                                begin
                                    elow_next   = seq_num;
                                    ehigh_next  = seq_num;
                                    emptyv_next = 1'b1;
                                end
                                else
                                begin
                                    ehigh_next = raise_high(ehigh_reg, seq_num);
                                    if (elow_reg < SEQ_LOW_BAND && seq_num > SEQ_HIGH_BAND)
                                    begin
                                        elow_next = seq_num;
                                    end
                                end
                            end
                            else
                            begin
                                seqv_next  = 1'b1;
                                low_next   = lb;
                                high_next  = raise_high(hb, seq_num);
                                len_next   = merge_first_byte ? {1'b0, size_bytes} :
                                             {1'b0, size_bytes} +
                                             (add_start_code ? START_CODE_BYTES : 17'd0);
                                nalu_next  = {1'b0, nalu_kind};
                                merge_next = merge_first_byte;
                                isf_next   = is_first;
                                mark_next  = marker;
                                stat_next  = STAT_OOW;
                                if (diff[18] && lb > SEQ_HIGH_BAND && seq_num < SEQ_LOW_BAND)
                                begin
                                    idx_u = 18'({2'b00, 16'hffff} - {2'b00, lb}
                                                 + {2'b00, seq_num} + 18'd1);
                                end
                                if (diff[18] && !(lb > SEQ_HIGH_BAND && seq_num < SEQ_LOW_BAND))
                                begin
                                    // Earlier packet: move the table up if there is room.
                                    if (room <= 18'(SLOTS))
                                    begin
                                        shift_next = sh16[IW-1:0];
                                        ptr_next   = (IW+1)'(hi_reg) + 1'b1;
                                        pk_next    = '0;
                                        low_next   = seq_num;
                                        state_next = S_SHIFT_RD;
                                    end
                                end
                                else if (idx_u < 18'(SLOTS))
                                begin
                                    pk_next    = idx_u[IW-1:0];
                                    state_next = S_PK_RD;
                                end
                            end
                        end

                        ACT_START:
                        begin
                            low_next    = seq_num;
                            high_next   = seq_num;
                            seqv_next   = 1'b1;
                            elow_next   = '0;
                            ehigh_next  = '0;
                            emptyv_next = 1'b0;
                            first_next  = 1'b0;
                            last_next   = 1'b0;
                            cmpl_next   = 1'b0;
                            kind_next   = '0;
                            hi_next     = '0;
                            ptr_next    = '0;
                            clres_next  = 1'b1;
                            state_next  = S_CLEAR;
                        end

                        ACT_FORCE:
                        begin
                            last_next = 1'b1;
                            if (first_reg)
                            begin
                                ptr_next    = '0;
                                allset_next = 1'b1;
                                off_next    = '0;
                                mov_next    = '0;
                                state_next  = S_WALK;
                            end
                        end

                        default:
                        begin
                            stat_next = STAT_CTRL;
                        end
                    endcase
                end
            end

            S_SHIFT_RD:
            begin
                rd_addr    = IW'(ptr_reg - 1'b1);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = IW'(ptr_reg - 1'b1 + (IW+1)'(shift_reg));
                wr_data  = rd_data;
                ptr_next = ptr_reg - 1'b1;
                if (ptr_reg == (IW+1)'(1))
                begin
                    ptr_next   = '0;
                    state_next = S_ZERO;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end

            S_ZERO:
            begin
                // Free the slots that the move opened below the old low.
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IW-1:0];
                wr_data  = SLOT_FREE;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg + 1'b1 == (IW+1)'(shift_reg))
                begin
                    hi_next    = hi_reg + shift_reg;
                    state_next = S_PK_RD;
                end
            end

            S_PK_RD:
            begin
                rd_addr    = pk_reg;
                state_next = S_PK_CHK;
            end

            S_PK_CHK:
            begin
                if (rd_data.size != 17'd0)
                begin
                    stat_next  = STAT_DUP;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = pk_reg;
                    wr_data     = '{size: len_reg, nalu: nalu_reg, merge: merge_reg};
                    if (pk_reg > hi_reg)
                    begin
                        hi_next = pk_reg;
                    end
                    first_next  = first_reg | isf_reg;
                    last_next   = last_reg | mark_reg;
                    stat_next   = STAT_STORED;
                    ptr_next    = '0;
                    allset_next = 1'b1;
                    off_next    = '0;
                    mov_next    = '0;
                    state_next  = S_WALK;
                end
            end

            S_WALK:
            begin
                // Issue one read a cycle and fold in the data of the previous one.
                if (ptr_reg <= (IW+1)'(hi_reg))
                begin
                    rd_addr    = ptr_reg[IW-1:0];
                    rdv_next   = 1'b1;
                    rdidx_next = ptr_reg[IW-1:0];
                    ptr_next   = ptr_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    if (rdidx_reg < pk_reg)
                    begin
                        off_next = off_reg + 23'(rd_data.size);
                    end
                    if (rdidx_reg > pk_reg)
                    begin
                        mov_next = mov_reg + 23'(rd_data.size);
                    end
                    if (rd_data.nalu == NALU_UNSET)
                    begin
                        allset_next = 1'b0;
                    end
                end
                else if (ptr_reg > (IW+1)'(hi_reg))
                begin
                    if (first_reg && last_reg)
                    begin
                        cmpl_next = allset_reg;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next      = 1'b1;
                    o_stat_next  = stat_reg;
                    if (stat_reg == STAT_STORED)
                    begin
                        o_len_next = len_reg;
                        o_idx_next = idx16[5:0];
                        o_off_next = off_reg;
                        o_mov_next = mov_reg;
                    end
                    else
                    begin
                        o_len_next = '0;
                        o_idx_next = '0;
                        o_off_next = '0;
                        o_mov_next = '0;
                    end
                    o_cmpl_next  = cmpl_reg;
                    o_first_next = first_reg;
                    o_last_next  = last_reg;
                    o_kind_next  = kind_reg;
                    o_low_next   = low_reg;
                    o_high_next  = emptyv_reg ? ehigh_reg : high_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            low_reg    <= '0;
            high_reg   <= '0;
            elow_reg   <= '0;
            ehigh_reg  <= '0;
            seqv_reg   <= 1'b0;
            emptyv_reg <= 1'b0;
            first_reg  <= 1'b0;
            last_reg   <= 1'b0;
            cmpl_reg   <= 1'b0;
            kind_reg   <= '0;
            hi_reg     <= '0;
            ptr_reg    <= '0;
            rdv_reg    <= 1'b0;
            clres_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            elow_reg   <= elow_next;
            ehigh_reg  <= ehigh_next;
            seqv_reg   <= seqv_next;
            emptyv_reg <= emptyv_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            cmpl_reg   <= cmpl_next;
            kind_reg   <= kind_next;
            hi_reg     <= hi_next;
            ptr_reg    <= ptr_next;
            rdv_reg    <= rdv_next;
            clres_reg  <= clres_next;
            ov_reg     <= ov_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        pk_reg      <= pk_next;
        shift_reg   <= shift_next;
        rdidx_reg   <= rdidx_next;
        allset_reg  <= allset_next;
        len_reg     <= len_next;
        nalu_reg    <= nalu_next;
        stat_reg    <= stat_next;
        merge_reg   <= merge_next;
        isf_reg     <= isf_next;
        mark_reg    <= mark_next;
        off_reg     <= off_next;
        mov_reg     <= mov_next;
        o_stat_reg  <= o_stat_next;
        o_len_reg   <= o_len_next;
        o_idx_reg   <= o_idx_next;
        o_off_reg   <= o_off_next;
        o_mov_reg   <= o_mov_next;
        o_cmpl_reg  <= o_cmpl_next;
        o_first_reg <= o_first_next;
        o_last_reg  <= o_last_next;
        o_kind_reg  <= o_kind_next;
        o_low_reg   <= o_low_next;
        o_high_reg  <= o_high_next;
    end

    assign out_valid      = ov_reg;
    assign status         = o_stat_reg;
    assign stored_length  = o_len_reg;
    assign slot_index     = o_idx_reg;
    assign byte_offset    = o_off_reg;
    assign bytes_to_move  = o_mov_reg;
    assign frame_complete = o_cmpl_reg;
    assign have_first     = o_first_reg;
    assign have_last      = o_last_reg;
    assign frame_kind_out = o_kind_reg;
    assign low_seq_out    = o_low_reg;
    assign high_seq_out   = o_high_reg;

endmodule

// ===== rtl/core/rfpst_slot_mem.sv =====
// Slot table memory: one write port and one read port, registered read data.
// Depends on rfpst_pkg for the slot entry type.
module rfpst_slot_mem #(
    parameter int SLOTS = rfpst_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  rfpst_pkg::slot_entry_t    wr_data,
    input  logic [AW-1:0]             rd_addr,
    output rfpst_pkg::slot_entry_t    rd_data
);
    import rfpst_pkg::*;

    slot_entry_t mem [SLOTS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
